FILE: design/string_prefix_to_number_unit_macros.svh
`ifndef STRING_PREFIX_TO_NUMBER_UNIT_MACROS_SVH
`define STRING_PREFIX_TO_NUMBER_UNIT_MACROS_SVH

// same-cycle implication
`define SPN_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SPN_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: design/spn_pkg.sv
package spn_pkg;

   localparam int DATA_W = 32;
   localparam int ADDR_W = 4;
   localparam int CHAR_W = 8;
   localparam int NUM_W  = 64;
   localparam int PLEN_W = 5;
   localparam int SPAN_W = 9;

   localparam logic signed [CHAR_W-1:0] LOWEST_RST  = 8'sd32;
   localparam logic signed [CHAR_W-1:0] HIGHEST_RST = 8'sd126;
   localparam logic [PLEN_W-1:0]        PREFIX_RST  = 5'd9;

   typedef enum logic [1:0] {
      REG_LOWEST  = 2'd0,
      REG_HIGHEST = 2'd1,
      REG_PREFIX  = 2'd2
   } reg_index_type;

   typedef enum logic {
      ST_IDLE,
      ST_CALC
   } state_type;

   typedef struct packed {
      logic signed [CHAR_W-1:0] lowest;
      logic signed [CHAR_W-1:0] highest;
      logic [PLEN_W-1:0]        prefix_len;
   } cfg_type;

   typedef struct packed {
      logic rebuild;
      logic rd_en;
   } tbl_ctrl_type;

endpackage

FILE: design/spn_if.sv
interface spn_req_if;
   logic                             valid;
   logic                             ready;
   logic signed [spn_pkg::CHAR_W-1:0] char_code;
   logic                             str_end;
   logic                             empty_string;

   modport source (output valid, char_code, str_end, empty_string, input ready);
   modport sink (input valid, char_code, str_end, empty_string, output ready);
endinterface

interface spn_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [spn_pkg::NUM_W-1:0]   number;
   logic                        was_clamped;
   logic                        bad_range;

   modport source (output valid, number, was_clamped, bad_range, input ready);
   modport sink (input valid, number, was_clamped, bad_range, output ready);
endinterface

FILE: design/spn_csr.sv
module spn_csr (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [spn_pkg::ADDR_W-1:0]   paddr,
   input  logic [spn_pkg::DATA_W-1:0]   pwdata,
   output logic [spn_pkg::DATA_W-1:0]   prdata,
   output logic                         pready,
   output spn_pkg::cfg_type             cfg,
   output logic                         cfg_wr
);

   spn_pkg::cfg_type       cfg_ff;
   spn_pkg::reg_index_type idx;
   logic                   wr_en;

   assign idx    = spn_pkg::reg_index_type'(paddr[spn_pkg::ADDR_W-1:2]);
   assign wr_en  = psel && penable && pwrite;
   assign cfg_wr = wr_en && (idx == spn_pkg::REG_LOWEST || idx == spn_pkg::REG_HIGHEST ||
                             idx == spn_pkg::REG_PREFIX);
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.lowest     <= spn_pkg::LOWEST_RST;
         cfg_ff.highest    <= spn_pkg::HIGHEST_RST;
         cfg_ff.prefix_len <= spn_pkg::PREFIX_RST;
      end else if (wr_en) begin
         unique case (idx)
            spn_pkg::REG_LOWEST:  cfg_ff.lowest     <= $signed(pwdata[spn_pkg::CHAR_W-1:0]);
            spn_pkg::REG_HIGHEST: cfg_ff.highest    <= $signed(pwdata[spn_pkg::CHAR_W-1:0]);
            spn_pkg::REG_PREFIX:  cfg_ff.prefix_len <= pwdata[spn_pkg::PLEN_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         spn_pkg::REG_LOWEST:
            prdata = {{(spn_pkg::DATA_W-spn_pkg::CHAR_W){1'b0}}, cfg_ff.lowest};
         spn_pkg::REG_HIGHEST:
            prdata = {{(spn_pkg::DATA_W-spn_pkg::CHAR_W){1'b0}}, cfg_ff.highest};
         spn_pkg::REG_PREFIX:
            prdata = {{(spn_pkg::DATA_W-spn_pkg::PLEN_W){1'b0}}, cfg_ff.prefix_len};
         default:
            prdata = '0;
      endcase
   end

endmodule

FILE: design/spn_weight_tbl.sv
module spn_weight_tbl #(
   parameter int PREFIX_MAX = 16,
   parameter int AW         = 4
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [spn_pkg::SPAN_W-1:0]  span,
   input  spn_pkg::tbl_ctrl_type       ctrl,
   input  logic [AW-1:0]               rd_addr,
   output logic [spn_pkg::NUM_W-1:0]   rd_data,
   output logic                        busy
);

   logic [spn_pkg::NUM_W-1:0] mem [PREFIX_MAX];
   logic [spn_pkg::NUM_W-1:0] rd_data_ff;
   logic [spn_pkg::NUM_W-1:0] wprev_ff;
   logic [spn_pkg::NUM_W-1:0] prod;
   logic [spn_pkg::NUM_W-1:0] entry_val;
   logic [AW-1:0]             bidx_ff;
   logic                      busy_ff;
   logic                      last_idx;

   assign prod      = spn_pkg::NUM_W'(wprev_ff * spn_pkg::NUM_W'(span));
   assign entry_val = (bidx_ff == '0) ? spn_pkg::NUM_W'(1) : prod + spn_pkg::NUM_W'(1);
   assign last_idx  = (bidx_ff == AW'(PREFIX_MAX-1));
   assign rd_data   = rd_data_ff;
   assign busy      = busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
         bidx_ff <= '0;
      end else if (ctrl.rebuild) begin
         busy_ff <= 1'b1;
         bidx_ff <= '0;
      end else if (busy_ff) begin
         if (last_idx) begin
            busy_ff <= 1'b0;
         end else begin
            bidx_ff <= bidx_ff + AW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (busy_ff) begin
         mem[bidx_ff] <= entry_val;
         wprev_ff     <= entry_val;
      end
      if (ctrl.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule

FILE: design/string_prefix_to_number_unit.sv
// String prefix to number unit.
// req carries one signed character per transaction with str_end and
// empty_string marks; rsp carries one transaction per string: the 64-bit
// code, a clamp flag and a bad-range flag. Registers lowest_char,
// highest_char and prefix_len sit on the APB port at byte addresses 0, 4, 8.
// Each character is accepted in the idle state, which reads the weight for its
// position from the weight table memory; the calc state that follows does one 64x8
// multiply-add into the accumulator. req.ready is low in the calc state, so the
// block takes no new character until the last one's multiply-add is done.
// The result of a string is loaded into the rsp register at the end of its
// last character's calc state.
// Reset and every register write rebuild the weight table, one entry per cycle;
// req.ready stays low meanwhile.
// When rsp stalls, the block keeps taking inner characters; a last character
// waits in its calc state until the rsp register is free.
module string_prefix_to_number_unit #(
   parameter int PREFIX_MAX = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   spn_req_if.sink                      req,
   spn_rsp_if.source                    rsp,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [spn_pkg::ADDR_W-1:0]   paddr,
   input  logic [spn_pkg::DATA_W-1:0]   pwdata,
   output logic [spn_pkg::DATA_W-1:0]   prdata,
   output logic                         pready
);

   localparam int PW = $clog2(PREFIX_MAX + 1);
   localparam int AW = (PREFIX_MAX > 1) ? $clog2(PREFIX_MAX) : 1;

   spn_pkg::cfg_type        cfg;
   spn_pkg::tbl_ctrl_type   tbl_ctrl;
   logic                    cfg_wr;
   logic                    tbl_busy;
   logic [spn_pkg::NUM_W-1:0] tbl_data;
   logic [spn_pkg::SPAN_W-1:0] span;
   logic [AW-1:0]           rd_addr;
   logic [PW-1:0]           addr_full;

   spn_pkg::state_type      state_ff, state_in;
   logic [PW-1:0]           pos_ff, pos_in;
   logic                    too_long_ff, too_long_in;
   logic                    clamp_seen_ff, clamp_seen_in;
   logic [spn_pkg::NUM_W-1:0] acc_ff, acc_in;

   logic [spn_pkg::CHAR_W-1:0] off_ff;
   logic                    use_ff, last_ff, empty_ff, bad_ff, clampo_ff;
   logic [1:0]              inc_ff;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [spn_pkg::NUM_W-1:0] number_ff;
   logic                    was_clamped_ff, bad_range_ff;

   logic                    req_fire, bad, in_prefix, below, above, clamp_now;
   logic                    clamp_next, toolong_next, use_now, load_out, result, out_free;
   logic [PW-1:0]           p_eff, pos_next;
   logic signed [spn_pkg::CHAR_W-1:0] c_cl;
   logic [spn_pkg::SPAN_W-1:0] diff;
   logic [spn_pkg::NUM_W-1:0] prod, sum;

   spn_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg),
      .cfg_wr  (cfg_wr)
   );

   spn_weight_tbl #(
      .PREFIX_MAX (PREFIX_MAX),
      .AW         (AW)
   ) u_tbl (
      .clock   (clock),
      .reset   (reset),
      .span    (span),
      .ctrl    (tbl_ctrl),
      .rd_addr (rd_addr),
      .rd_data (tbl_data),
      .busy    (tbl_busy)
   );

   assign span = {cfg.highest[spn_pkg::CHAR_W-1], cfg.highest}
               - {cfg.lowest[spn_pkg::CHAR_W-1], cfg.lowest} + spn_pkg::SPAN_W'(1);

   assign req.ready = (state_ff == spn_pkg::ST_IDLE) && !tbl_busy;
   assign req_fire  = req.valid && req.ready;

   assign tbl_ctrl.rebuild = cfg_wr;
   assign tbl_ctrl.rd_en   = req_fire;

   always_comb begin
      if (cfg.prefix_len == '0) begin
         p_eff = PW'(1);
      end else if (32'(cfg.prefix_len) > PREFIX_MAX) begin
         p_eff = PW'(PREFIX_MAX);
      end else begin
         p_eff = PW'(cfg.prefix_len);
      end
   end

   assign bad       = cfg.lowest > cfg.highest;
   assign in_prefix = pos_ff < p_eff;
   assign below     = req.char_code < cfg.lowest;
   assign above     = req.char_code > cfg.highest;
   assign clamp_now = !bad && (below || above);
   assign c_cl      = below ? cfg.lowest : (above ? cfg.highest : req.char_code);
   assign diff      = {c_cl[spn_pkg::CHAR_W-1], c_cl}
                    - {cfg.lowest[spn_pkg::CHAR_W-1], cfg.lowest};
   assign addr_full = p_eff - pos_ff - PW'(1);
   assign rd_addr   = addr_full[AW-1:0];

   assign clamp_next   = clamp_seen_ff || clamp_now;
   assign toolong_next = too_long_ff || !in_prefix;
   assign pos_next     = in_prefix ? pos_ff + PW'(1) : pos_ff;
   assign use_now      = !req.empty_string && in_prefix && !bad;

   assign prod     = spn_pkg::NUM_W'(tbl_data * spn_pkg::NUM_W'(off_ff));
   assign sum      = acc_ff + (use_ff ? prod : '0) + spn_pkg::NUM_W'(inc_ff);
   assign result   = last_ff || empty_ff;
   assign out_free = !rsp_valid_ff || rsp.ready;

   always_comb begin
      state_in      = state_ff;
      pos_in        = pos_ff;
      too_long_in   = too_long_ff;
      clamp_seen_in = clamp_seen_ff;
      acc_in        = acc_ff;
      load_out      = 1'b0;
      unique case (state_ff)
         spn_pkg::ST_IDLE: begin
            if (req_fire) begin
               state_in = spn_pkg::ST_CALC;
               if (req.empty_string || req.str_end) begin
                  pos_in        = '0;
                  too_long_in   = 1'b0;
                  clamp_seen_in = 1'b0;
               end else begin
                  pos_in        = pos_next;
                  too_long_in   = toolong_next;
                  clamp_seen_in = clamp_next;
               end
            end
         end
         spn_pkg::ST_CALC: begin
            if (!result || out_free) begin
               state_in = spn_pkg::ST_IDLE;
               load_out = result;
               acc_in   = result ? '0 : sum;
            end
         end
         default: state_in = spn_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= spn_pkg::ST_IDLE;
         pos_ff        <= '0;
         too_long_ff   <= 1'b0;
         clamp_seen_ff <= 1'b0;
         acc_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pos_ff        <= pos_in;
         too_long_ff   <= too_long_in;
         clamp_seen_ff <= clamp_seen_in;
         acc_ff        <= acc_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         off_ff    <= diff[spn_pkg::CHAR_W-1:0];
         use_ff    <= use_now;
         inc_ff    <= {1'b0, use_now}
                    + {1'b0, !req.empty_string && req.str_end && toolong_next};
         last_ff   <= req.str_end;
         empty_ff  <= req.empty_string;
         bad_ff    <= bad;
         clampo_ff <= clamp_next;
      end
      if (load_out) begin
         number_ff      <= (bad_ff || empty_ff) ? '0 : sum;
         was_clamped_ff <= !(bad_ff || empty_ff) && clampo_ff;
         bad_range_ff   <= bad_ff;
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.number      = number_ff;
   assign rsp.was_clamped = was_clamped_ff;
   assign rsp.bad_range   = bad_range_ff;

`include "string_prefix_to_number_unit_macros.svh"

   `SPN_ASSERT_NEXT(a_accept_to_calc, clock, reset, req.valid && req.ready,
      state_ff == spn_pkg::ST_CALC, "accepted transaction did not enter calc")
   `SPN_ASSERT_NOW(a_no_accept_busy, clock, reset, tbl_busy, !req.ready,
      "input ready while weight table rebuilds")
   `SPN_ASSERT_NOW(a_bad_range_zero, clock, reset, rsp.valid && rsp.bad_range,
      rsp.number == '0 && !rsp.was_clamped, "bad range result not zero")

endmodule
